// File: rtl/range_max_segment_tree_assert.svh
// ----------------------------------------------------------------------------
// range_max_segment_tree_assert.svh
// assertion macros used by the segment tree rtl
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MAX_SEGMENT_TREE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RMST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RMST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RMST_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// shared types and constants of the range maximum segment tree
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmst_pkg;

   localparam int DATA_W         = 32;
   localparam int INDEX_W        = 10;
   localparam int LEAVES_DEFAULT = 1024;

   // value of a node that holds no written leaf
   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1000000003;

   // request opcodes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // operations of the shared max unit
   typedef enum logic [1:0] {
      ACC_IDLE,
      ACC_LOAD_RD,
      ACC_MAX_RD,
      ACC_LOAD_EXT
   } acc_op_type;

   typedef struct packed {
      acc_op_type op;
   } acc_ctrl_type;

endpackage

// File: rtl/rmst_node_ram.sv
// ----------------------------------------------------------------------------
// rmst_node_ram
// tree node storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmst_node_ram #(
   parameter int ADDR_W = 11
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ADDR_W-1:0]               wr_addr,
   input  logic [rmst_pkg::DATA_W-1:0]     wr_data,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [rmst_pkg::DATA_W-1:0]     rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [rmst_pkg::DATA_W-1:0] mem [0:DEPTH-1];
   logic [rmst_pkg::DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rmst_max_unit.sv
// ----------------------------------------------------------------------------
// rmst_max_unit
// shared signed max comparator with a running-maximum register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmst_max_unit (
   input  logic                                clock,
   input  rmst_pkg::acc_ctrl_type              ctrl,
   input  logic signed [rmst_pkg::DATA_W-1:0]  ext_value,
   input  logic signed [rmst_pkg::DATA_W-1:0]  rd_data,
   output logic signed [rmst_pkg::DATA_W-1:0]  best,
   output logic signed [rmst_pkg::DATA_W-1:0]  merged
);

   logic signed [rmst_pkg::DATA_W-1:0] best_ff;

   // the one comparator of the block
   assign merged = (rd_data > best_ff) ? rd_data : best_ff;

   // running maximum
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         rmst_pkg::ACC_IDLE:     best_ff <= best_ff;
         rmst_pkg::ACC_LOAD_RD:  best_ff <= rd_data;
         rmst_pkg::ACC_MAX_RD:   best_ff <= merged;
         rmst_pkg::ACC_LOAD_EXT: best_ff <= ext_value;
         default:                best_ff <= best_ff;
      endcase
   end

   assign best = best_ff;

endmodule

// File: rtl/range_max_segment_tree.sv
// ----------------------------------------------------------------------------
// range_max_segment_tree
// segment tree of signed maxima with point update and range maximum query
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 2*SPAN node entries
// (SPAN is LEAVES rounded up to a power of two) that sets every node to the
// empty value; req_stall stays high meanwhile. After a request beat
// req_stall stays high until an update has written every node on its path
// up to the root, or until a query has handed its result to the output
// register; a query with a reversed range goes straight to that hand-off.
// An update with a start index out of range is dropped. A query also waits
// in its final state while an earlier result is stalled in the output
// register. All node traffic goes through one RAM read port with registered
// data and one shared signed max unit: a sibling node is read, and in the
// next cycle it is folded into the running maximum (and, for an update, the
// parent is written). One item is worked on at a time; a finished query
// result sits in an output register so the next item is taken while it
// waits.
`timescale 1ns / 1ps

`include "range_max_segment_tree_assert.svh"

module range_max_segment_tree #(
   parameter int LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [rmst_pkg::INDEX_W-1:0]        req_index_start,
   input  logic [rmst_pkg::INDEX_W-1:0]        req_index_end,
   input  logic signed [rmst_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rmst_pkg::DATA_W-1:0]  rsp_max_value,
   output logic                                rsp_range_error
);

   localparam int SPAN_W = $clog2(LEAVES);
   localparam int SPAN   = 1 << SPAN_W;
   localparam int NODE_W = SPAN_W + 1;
   localparam logic [NODE_W-1:0] SPAN_NODE = NODE_W'(SPAN);
   localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
   localparam logic [NODE_W-1:0] LAST_NODE = {NODE_W{1'b1}};
   localparam logic [rmst_pkg::INDEX_W-1:0] LEAF_LAST = rmst_pkg::INDEX_W'(LEAVES - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_U_LEAF,
      ST_U_READ,
      ST_U_WRITE,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_Q_WALK,
      ST_Q_DONE
   } state_type;

   state_type                          state_ff;
   logic [NODE_W-1:0]                  clr_ff;
   logic [NODE_W-1:0]                  l_ff;
   logic [NODE_W-1:0]                  r_ff;
   logic                               side_ff;
   logic                               err_ff;
   logic signed [rmst_pkg::DATA_W-1:0] value_ff;
   rmst_pkg::acc_ctrl_type             acc_ctrl_ff;
   rmst_pkg::acc_op_type               acc_op_in;
   logic                               rsp_valid_ff;
   logic signed [rmst_pkg::DATA_W-1:0] rsp_max_ff;
   logic                               rsp_err_ff;

   logic                               req_beat;
   logic                               rsp_free;
   logic [rmst_pkg::INDEX_W-1:0]       start_sat;
   logic [rmst_pkg::INDEX_W-1:0]       end_sat;
   logic                               start_in_range;
   logic                               end_in_range;
   logic                               parents_equal;

   logic                               mem_wr_en;
   logic [NODE_W-1:0]                  mem_wr_addr;
   logic [rmst_pkg::DATA_W-1:0]        mem_wr_data;
   logic [NODE_W-1:0]                  mem_rd_addr;
   logic [rmst_pkg::DATA_W-1:0]        mem_rd_data;
   logic signed [rmst_pkg::DATA_W-1:0] acc_best;
   logic signed [rmst_pkg::DATA_W-1:0] acc_merged;

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // leaf index bounds and saturation
   assign start_in_range = (32'(req_index_start) < LEAVES);
   assign end_in_range   = (32'(req_index_end) < LEAVES);
   assign start_sat      = start_in_range ? req_index_start : LEAF_LAST;
   assign end_sat        = end_in_range ? req_index_end : LEAF_LAST;

   // walk ends once both ends share a parent
   assign parents_equal = (l_ff[NODE_W-1:1] == r_ff[NODE_W-1:1]);

   // node ram port steering
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_ff;
      mem_wr_data = rmst_pkg::EMPTY_VALUE;
      mem_rd_addr = l_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_U_LEAF: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = l_ff;
            mem_wr_data = value_ff;
         end
         ST_U_READ: begin
            mem_rd_addr = l_ff ^ ROOT_NODE;
         end
         ST_U_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = l_ff >> 1;
            mem_wr_data = acc_merged;
         end
         ST_Q_LEFT: begin
            mem_rd_addr = l_ff;
         end
         ST_Q_RIGHT: begin
            mem_rd_addr = r_ff;
         end
         ST_Q_WALK: begin
            if (!side_ff && !l_ff[0]) begin
               mem_rd_addr = l_ff ^ ROOT_NODE;
            end else begin
               mem_rd_addr = r_ff ^ ROOT_NODE;
            end
         end
         ST_IDLE, ST_Q_DONE: begin
            mem_rd_addr = l_ff;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // next operation of the shared max unit
   always_comb begin
      acc_op_in = rmst_pkg::ACC_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_op == rmst_pkg::OP_UPDATE) && start_in_range) begin
               acc_op_in = rmst_pkg::ACC_LOAD_EXT;
            end
         end
         ST_U_READ, ST_Q_RIGHT: begin
            acc_op_in = rmst_pkg::ACC_MAX_RD;
         end
         ST_Q_LEFT: begin
            acc_op_in = rmst_pkg::ACC_LOAD_RD;
         end
         ST_Q_WALK: begin
            if (!parents_equal && ((!side_ff && !l_ff[0]) || r_ff[0])) begin
               acc_op_in = rmst_pkg::ACC_MAX_RD;
            end
         end
         default: begin
            acc_op_in = rmst_pkg::ACC_IDLE;
         end
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         acc_ctrl_ff.op  <= rmst_pkg::ACC_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         acc_ctrl_ff.op <= acc_op_in;
         // load a new result beat or let the held one go
         if ((state_ff == ST_Q_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            // clear one node per cycle
            ST_CLEAR: begin
               clr_ff <= clr_ff + NODE_W'(1);
               if (clr_ff == LAST_NODE) begin
                  state_ff <= ST_IDLE;
               end
            end
            // take a request beat
            ST_IDLE: begin
               if (req_beat) begin
                  if (req_op == rmst_pkg::OP_UPDATE) begin
                     l_ff     <= SPAN_NODE + NODE_W'(req_index_start);
                     value_ff <= req_value;
                     if (start_in_range) begin
                        state_ff <= ST_U_LEAF;
                     end
                  end else begin
                     l_ff    <= SPAN_NODE + NODE_W'(start_sat);
                     r_ff    <= SPAN_NODE + NODE_W'(end_sat);
                     side_ff <= 1'b0;
                     err_ff  <= (req_index_start > req_index_end);
                     if (req_index_start > req_index_end) begin
                        state_ff <= ST_Q_DONE;
                     end else begin
                        state_ff <= ST_Q_LEFT;
                     end
                  end
               end
            end
            // update: leaf written, climb toward the root
            ST_U_LEAF: begin
               state_ff <= ST_U_READ;
            end
            ST_U_READ: begin
               state_ff <= ST_U_WRITE;
            end
            ST_U_WRITE: begin
               l_ff <= l_ff >> 1;
               if ((l_ff >> 1) == ROOT_NODE) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_U_READ;
               end
            end
            // query: both end leaves first
            ST_Q_LEFT: begin
               state_ff <= ST_Q_RIGHT;
            end
            ST_Q_RIGHT: begin
               state_ff <= ST_Q_WALK;
            end
            // query: fold in-range siblings level by level
            ST_Q_WALK: begin
               if (parents_equal) begin
                  state_ff <= ST_Q_DONE;
               end else if (!side_ff && !l_ff[0]) begin
                  side_ff <= 1'b1;
               end else begin
                  l_ff    <= l_ff >> 1;
                  r_ff    <= r_ff >> 1;
                  side_ff <= 1'b0;
               end
            end
            // hand the result to the output register
            ST_Q_DONE: begin
               if (rsp_free) begin
                  rsp_max_ff <= err_ff ? rmst_pkg::EMPTY_VALUE : acc_best;
                  rsp_err_ff <= err_ff;
                  state_ff   <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_value   = rsp_max_ff;
   assign rsp_range_error = rsp_err_ff;

   // node storage
   rmst_node_ram #(
      .ADDR_W (NODE_W)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // shared max unit
   rmst_max_unit u_max_unit (
      .clock     (clock),
      .ctrl      (acc_ctrl_ff),
      .ext_value (value_ff),
      .rd_data   (mem_rd_data),
      .best      (acc_best),
      .merged    (acc_merged)
   );

   // checks
   `RMST_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid),
                    $past(state_ff == ST_Q_DONE), "result beat without a finished query")
   `RMST_ASSERT_IMP(a_err_is_empty, clock, reset, rsp_valid && rsp_range_error,
                    rsp_max_value == rmst_pkg::EMPTY_VALUE, "reversed range lost empty value")
   `RMST_ASSERT_IMP(a_walk_ordered, clock, reset, state_ff == ST_Q_WALK,
                    l_ff <= r_ff, "query walk ends crossed")
   `RMST_ASSERT_IMP(a_update_below_root, clock, reset, state_ff == ST_U_WRITE,
                    l_ff > ROOT_NODE, "update climbed past the root")
   `RMST_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_max_value), "stalled result beat changed")

endmodule

// File: tb/tb_range_max_segment_tree.sv
// ----------------------------------------------------------------------------
// tb_range_max_segment_tree
// self-checking bench for the range maximum segment tree
// ----------------------------------------------------------------------------
// Sends leaf updates and range queries through the request channel with
// random gaps, and stalls the result channel at random. A shadow copy of
// the leaves predicts every query result (max over the range, or the empty
// value with the error flag on a reversed range). Each result beat is
// checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_range_max_segment_tree;

   localparam int DATA_W       = rmst_pkg::DATA_W;
   localparam int INDEX_W      = rmst_pkg::INDEX_W;
   localparam int LEAVES       = rmst_pkg::LEAVES_DEFAULT;
   localparam int RANDOM_ITEMS = 1630;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic signed [DATA_W-1:0] max_value;
      logic                     range_error;
   } query_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_op;
   logic [INDEX_W-1:0]         req_index_start;
   logic [INDEX_W-1:0]         req_index_end;
   logic signed [DATA_W-1:0]   req_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [DATA_W-1:0]   rsp_max_value;
   logic                       rsp_range_error;

   logic signed [DATA_W-1:0]   shadow_leaves [0:LEAVES-1];
   query_result_type           pending_maxima [$];
   int                         fail_count  = 0;
   int                         idle_cycles = 0;
   int                         stall_hold  = 0;
   bit                         quiet_mode  = 1'b0;

   range_max_segment_tree #(
      .LEAVES(LEAVES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_index_start (req_index_start),
      .req_index_end   (req_index_end),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_max_value   (rsp_max_value),
      .rsp_range_error (rsp_range_error)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle length: mostly none or short, a few long, none in quiet stretches
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // leaf value mix: full range, small negatives, around empty, large negatives
   function automatic logic signed [DATA_W-1:0] leaf_value();
      unique case ($urandom_range(0, 3))
         0: return $urandom;
         1: return -$signed(DATA_W'($urandom_range(0, 1000)));
         2: return rmst_pkg::EMPTY_VALUE + $signed(DATA_W'($urandom_range(0, 4))) - 2;
         default: return $urandom | 32'h8000_0000;
      endcase
   endfunction

   // shadow leaf update or query prediction for one accepted request beat
   task automatic track_tree_item(input logic op, input logic [INDEX_W-1:0] first,
                                  input logic [INDEX_W-1:0] last,
                                  input logic signed [DATA_W-1:0] val);
      query_result_type peak;
      int               lo;
      int               hi;
      peak.max_value   = rmst_pkg::EMPTY_VALUE;
      peak.range_error = 1'b0;
      if (op == rmst_pkg::OP_UPDATE) begin
         if (first < LEAVES) shadow_leaves[first] = val;
      end else begin
         if (first > last) begin
            peak.range_error = 1'b1;
         end else begin
            lo = (first >= LEAVES) ? LEAVES - 1 : int'(first);
            hi = (last >= LEAVES) ? LEAVES - 1 : int'(last);
            // leaves may sit below the empty value, so start from the first one
            peak.max_value = shadow_leaves[lo];
            for (int i = lo + 1; i <= hi; i++)
               if (shadow_leaves[i] > peak.max_value) peak.max_value = shadow_leaves[i];
         end
         pending_maxima.push_back(peak);
      end
   endtask

   // drive one request beat after a random gap and wait for acceptance
   task automatic send_item(input logic op, input logic [INDEX_W-1:0] first,
                            input logic [INDEX_W-1:0] last,
                            input logic signed [DATA_W-1:0] val);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op          = op;
      req_index_start = first;
      req_index_end   = last;
      req_value       = val;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      track_tree_item(op, first, last, val);
   endtask

   // queries on the freshly cleared tree
   task automatic test_cleared_tree();
      send_item(rmst_pkg::OP_QUERY, 10'd0, 10'd1023, $urandom);
      send_item(rmst_pkg::OP_QUERY, 10'd0, 10'd0, $urandom);
      send_item(rmst_pkg::OP_QUERY, 10'd1023, 10'd1023, $urandom);
   endtask

   // reversed ranges give the empty value with the error flag
   task automatic test_reversed_range();
      send_item(rmst_pkg::OP_QUERY, 10'd1, 10'd0, 32'sd0);
      send_item(rmst_pkg::OP_QUERY, 10'd1023, 10'd0, 32'h7fff_ffff);
      send_item(rmst_pkg::OP_QUERY, 10'd513, 10'd512, -32'sd1);
   endtask

   // extreme indexes and values, values at and below empty, ignored fields
   task automatic test_leaf_extremes();
      send_item(rmst_pkg::OP_UPDATE, 10'd0, 10'd0, 32'h7fff_ffff);
      send_item(rmst_pkg::OP_UPDATE, 10'd1023, 10'd0, 32'h8000_0000);
      send_item(rmst_pkg::OP_QUERY, 10'd0, 10'd1023, 32'h8000_0000);
      send_item(rmst_pkg::OP_QUERY, 10'd1023, 10'd1023, $urandom);
      send_item(rmst_pkg::OP_QUERY, 10'd1000, 10'd1023, $urandom);
      send_item(rmst_pkg::OP_UPDATE, 10'd512, 10'h3ff, rmst_pkg::EMPTY_VALUE);
      send_item(rmst_pkg::OP_UPDATE, 10'd511, 10'd200, -32'sd1);
      send_item(rmst_pkg::OP_QUERY, 10'd500, 10'd600, 32'sd0);
      send_item(rmst_pkg::OP_QUERY, 10'd512, 10'd512, 32'hffff_ffff);
      send_item(rmst_pkg::OP_UPDATE, 10'd0, 10'd1023, -32'sd5);
      send_item(rmst_pkg::OP_QUERY, 10'd0, 10'd1, $urandom);
      send_item(rmst_pkg::OP_UPDATE, 10'd1023, 10'd0, 32'sd0);
      send_item(rmst_pkg::OP_QUERY, 10'd0, 10'd1023, $urandom);
      send_item(rmst_pkg::OP_UPDATE, 10'd1023, 10'd1023, 32'h8000_0001);
      send_item(rmst_pkg::OP_QUERY, 10'd768, 10'd1023, $urandom);
   endtask

   // random traffic focused on windows of leaves so that leaves get overwritten
   task automatic test_random_windows();
      int sent;
      int base;
      int width;
      int burst;
      int r;
      int a;
      int b;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet_mode = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 9);
         width = (r < 5) ? $urandom_range(2, 16) :
                 (r < 9) ? $urandom_range(17, 128) : LEAVES;
         base  = $urandom_range(0, LEAVES - width);
         burst = $urandom_range(20, 60);
         for (int k = 0; k < burst; k++) begin
            r = $urandom_range(0, 99);
            a = base + $urandom_range(0, width - 1);
            b = base + $urandom_range(0, width - 1);
            if (r < 48) begin
               send_item(rmst_pkg::OP_UPDATE, INDEX_W'(a), INDEX_W'($urandom), leaf_value());
            end else if (r < 93) begin
               if (r < 52) begin
                  a = base;
                  b = base + width - 1;
               end
               if (a > b) send_item(rmst_pkg::OP_QUERY, INDEX_W'(b), INDEX_W'(a), $urandom);
               else send_item(rmst_pkg::OP_QUERY, INDEX_W'(a), INDEX_W'(b), $urandom);
            end else if (r < 97) begin
               a = $urandom_range(0, LEAVES - 1);
               b = (r == 96) ? LEAVES - 1 : $urandom_range(a, LEAVES - 1);
               if (r == 95) a = 0;
               send_item(rmst_pkg::OP_QUERY, INDEX_W'(a), INDEX_W'(b), $urandom);
            end else begin
               a = $urandom_range(1, LEAVES - 1);
               b = $urandom_range(0, a - 1);
               send_item(rmst_pkg::OP_QUERY, INDEX_W'(a), INDEX_W'(b), $urandom);
            end
            sent++;
         end
      end
      quiet_mode = 1'b0;
   endtask

   // result channel stall pattern
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet_mode) begin
            rsp_stall  = 1'b0;
            stall_hold = 0;
         end else if (stall_hold > 0) begin
            rsp_stall  = 1'b1;
            stall_hold = stall_hold - 1;
         end else begin
            rsp_stall  = 1'b0;
            stall_hold = idle_len();
         end
      end
   end

   // check each result beat against the oldest prediction
   always @(posedge clock) begin : check_beat
      query_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_maxima.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result beat, max_value %0d range_error %0b",
                     $time, rsp_max_value, rsp_range_error);
         end else begin
            want = pending_maxima.pop_front();
            if (rsp_max_value !== want.max_value) begin
               fail_count++;
               $display("%0t: max_value expected %0d actual %0d",
                        $time, want.max_value, rsp_max_value);
            end
            if (rsp_range_error !== want.range_error) begin
               fail_count++;
               $display("%0t: range_error expected %0b actual %0b",
                        $time, want.range_error, rsp_range_error);
            end
         end
      end
   end

   // cycles with no beat accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // watchdog
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // main sequence
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = rmst_pkg::OP_UPDATE;
      req_index_start = '0;
      req_index_end   = '0;
      req_value       = '0;
      for (int i = 0; i < LEAVES; i++) shadow_leaves[i] = rmst_pkg::EMPTY_VALUE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_tree();
      test_reversed_range();
      test_leaf_extremes();
      test_random_windows();

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_maxima.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
